/* hw/rtl/ptdd_pkg.sv */
// ----------------------------------------------------------------------------
// Polar mixer package
// Shared constants, register codes and word types of the polar to
// differential-drive mixer.
// ----------------------------------------------------------------------------
package ptdd_pkg;

  // Field widths.
  localparam int unsigned ANGLE_W  = 16;
  localparam int unsigned MAG_W    = 16;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned PULSE_W  = 16;
  localparam int unsigned DUTY_W   = 14;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  // Duty scale and quadrant constants.
  localparam int unsigned HALF_PI_Q13  = 12868;
  localparam int unsigned DUTY_FULL    = 10000;
  localparam int unsigned DUTY_SPAN    = 20000;
  localparam int unsigned RAMP_OFFSET  = DUTY_FULL * HALF_PI_Q13;
  // Largest scaled ramp value that still matters; above it the duty clamps.
  localparam int unsigned RAMP_Y_MAX   = (DUTY_FULL + 1) * HALF_PI_Q13;
  localparam int unsigned PERIOD_RESET = 10000;

  // Reciprocals for constant division, scaled by two to the RECIP_SHIFT.
  localparam int unsigned RECIP_SHIFT = 32;
  localparam longint unsigned HALF_PI_RECIP =
      (longint'(1) << RECIP_SHIFT) / HALF_PI_Q13;
  localparam longint unsigned TICK_RECIP =
      (longint'(1) << RECIP_SHIFT) / DUTY_FULL;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RIGHT_PERIOD = 8'd0,
    REG_LEFT_PERIOD  = 8'd1
  } cfg_reg_t;

  // A wheel duty as a forward flag and a magnitude of at most full scale.
  typedef struct packed {
    logic              pos;
    logic [DUTY_W-1:0] mag;
  } duty_t;

  typedef struct packed {
    duty_t right;
    duty_t left;
  } duty_pair_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] right;
    logic [PERIOD_W-1:0] left;
  } period_pair_t;

endpackage

/* hw/rtl/ptdd_cmd_if.sv */
// ----------------------------------------------------------------------------
// Command channel
// Carries one joystick command word: angle and magnitude.
// ----------------------------------------------------------------------------
interface ptdd_cmd_if;
  import ptdd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] angle;
  logic        [MAG_W-1:0]   magnitude;

  modport source (output valid, output angle, output magnitude, input ready);
  modport sink   (input valid, input angle, input magnitude, output ready);
endinterface

/* hw/rtl/ptdd_width_if.sv */
// ----------------------------------------------------------------------------
// Pulse width channel
// Carries one result word: the four PWM pulse widths.
// ----------------------------------------------------------------------------
interface ptdd_width_if;
  import ptdd_pkg::*;

  logic               valid;
  logic               ready;
  logic [PULSE_W-1:0] right_forward_width;
  logic [PULSE_W-1:0] right_reverse_width;
  logic [PULSE_W-1:0] left_forward_width;
  logic [PULSE_W-1:0] left_reverse_width;

  modport source (
    output valid, output right_forward_width, output right_reverse_width,
    output left_forward_width, output left_reverse_width, input ready
  );
  modport sink (
    input valid, input right_forward_width, input right_reverse_width,
    input left_forward_width, input left_reverse_width, output ready
  );
endinterface

/* hw/rtl/ptdd_cfg_if.sv */
// ----------------------------------------------------------------------------
// Configuration channel
// Carries one register write word: register index and data.
// ----------------------------------------------------------------------------
interface ptdd_cfg_if;
  import ptdd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/ptdd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the right and left PWM periods; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module ptdd_cfg_regs (
  input  logic                  clk,
  input  logic                  rst,
  ptdd_cfg_if.sink              cfg,
  output ptdd_pkg::period_pair_t periods
);
  import ptdd_pkg::*;

  // Writes are always taken.
  assign cfg.ready = 1'b1;

  // Period registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      periods.right <= PERIOD_W'(PERIOD_RESET);
      periods.left  <= PERIOD_W'(PERIOD_RESET);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_RIGHT_PERIOD: periods.right <= cfg.data;
        REG_LEFT_PERIOD:  periods.left  <= cfg.data;
        default: begin
        end
      endcase
    end
  end
endmodule

/* hw/rtl/ptdd_ramp.sv */
// ----------------------------------------------------------------------------
// Duty mixer pipeline
// Four stages: quadrant decode, magnitude multiply, reciprocal divide by
// pi/2, and quotient correction with clamping and wheel assignment.
// ----------------------------------------------------------------------------
module ptdd_ramp (
  input  logic                 clk,
  input  logic                 rst,
  ptdd_cmd_if.sink             cmd,
  output logic                 duty_valid,
  input  logic                 duty_ready,
  output ptdd_pkg::duty_pair_t duty
);
  import ptdd_pkg::*;

  // Stage registers.
  logic              s1_valid, s2_valid, s3_valid;
  logic [MAG_W-1:0]  s1_mag;
  logic [28:0]       s1_t_abs;
  logic              s1_t_neg, s2_t_neg, s3_t_neg;
  logic              s1_ramp_right, s2_ramp_right, s3_ramp_right;
  logic              s1_full_pos, s2_full_pos, s3_full_pos;
  logic [29:0]       s2_y;
  logic [14:0]       s2_full;
  logic [26:0]       s3_y;
  logic [DUTY_W-1:0] s3_quot;
  logic [DUTY_W-1:0] s3_full;

  // Stage load enables; a stage loads when empty or when its word moves on.
  logic s1_load, s2_load, s3_load, s4_load;
  assign s4_load   = !duty_valid || duty_ready;
  assign s3_load   = !s3_valid || s4_load;
  assign s2_load   = !s2_valid || s3_load;
  assign s1_load   = !s1_valid || s2_load;
  assign cmd.ready = s1_load;

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      s3_valid   <= 1'b0;
      duty_valid <= 1'b0;
    end else begin
      if (s1_load) s1_valid   <= cmd.valid;
      if (s2_load) s2_valid   <= s1_valid;
      if (s3_load) s3_valid   <= s2_valid;
      if (s4_load) duty_valid <= s3_valid;
    end
  end

  // Stage 1: pick quadrant, angle inside it, and the ramp numerator.
  logic [16:0] ang_ext, ang_abs;
  logic        ang_pos, over;
  logic [14:0] quad_arg;
  logic [28:0] arg_span;
  logic        t_neg;
  logic [28:0] t_abs;

  always_comb begin
    ang_ext  = {cmd.angle[ANGLE_W-1], cmd.angle};
    ang_pos  = !cmd.angle[ANGLE_W-1] && (cmd.angle != '0);
    ang_abs  = ang_pos ? ang_ext : (17'd0 - ang_ext);
    over     = ang_abs > 17'(HALF_PI_Q13);
    quad_arg = over ? 15'(ang_abs - 17'(HALF_PI_Q13)) : 15'(ang_abs);
    arg_span = 29'(quad_arg) * 29'(DUTY_SPAN);
    t_neg    = arg_span < 29'(RAMP_OFFSET);
    t_abs    = t_neg ? (29'(RAMP_OFFSET) - arg_span) : (arg_span - 29'(RAMP_OFFSET));
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_mag        <= cmd.magnitude;
      s1_t_abs      <= t_abs;
      s1_t_neg      <= t_neg;
      s1_ramp_right <= ang_pos ^ over;
      s1_full_pos   <= over;
    end
  end

  // Stage 2: scale by magnitude and drop the Q1.15 fraction.
  logic [44:0] ramp_prod;
  logic [29:0] full_prod;

  always_comb begin
    ramp_prod = 45'(s1_mag) * 45'(s1_t_abs);
    full_prod = 30'(s1_mag) * 30'(DUTY_FULL);
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_y          <= ramp_prod[44:15];
      s2_full       <= full_prod[29:15];
      s2_t_neg      <= s1_t_neg;
      s2_ramp_right <= s1_ramp_right;
      s2_full_pos   <= s1_full_pos;
    end
  end

  // Stage 3: saturate, then estimate the quotient by pi/2 with a reciprocal.
  logic [26:0] y_sat;
  logic [45:0] recip_prod;

  always_comb begin
    y_sat      = (s2_y > 30'(RAMP_Y_MAX)) ? 27'(RAMP_Y_MAX) : s2_y[26:0];
    recip_prod = 46'(y_sat) * 46'(HALF_PI_RECIP);
  end

  always_ff @(posedge clk) begin
    if (s3_load) begin
      s3_y          <= y_sat;
      s3_quot       <= recip_prod[45:32];
      s3_full       <= (s2_full > 15'(DUTY_FULL)) ? DUTY_W'(DUTY_FULL) : s2_full[13:0];
      s3_t_neg      <= s2_t_neg;
      s3_ramp_right <= s2_ramp_right;
      s3_full_pos   <= s2_full_pos;
    end
  end

  // Stage 4: the estimate is at most one low; fix it, clamp, assign wheels.
  logic [26:0]       quot_rem;
  logic [DUTY_W-1:0] quot_fix;
  duty_t             ramp_duty, full_duty;

  always_comb begin
    quot_rem      = s3_y - 27'(s3_quot) * 27'(HALF_PI_Q13);
    quot_fix      = s3_quot + DUTY_W'(quot_rem >= 27'(HALF_PI_Q13));
    ramp_duty.pos = !s3_t_neg;
    ramp_duty.mag = (quot_fix > DUTY_W'(DUTY_FULL)) ? DUTY_W'(DUTY_FULL) : quot_fix;
    full_duty.pos = s3_full_pos;
    full_duty.mag = s3_full;
  end

  always_ff @(posedge clk) begin
    if (s4_load) begin
      duty.right <= s3_ramp_right ? ramp_duty : full_duty;
      duty.left  <= s3_ramp_right ? full_duty : ramp_duty;
    end
  end
endmodule

/* hw/rtl/ptdd_scale.sv */
// ----------------------------------------------------------------------------
// Pulse width scaler
// Three stages per wheel: period times duty, reciprocal divide by full
// scale, and quotient correction with the forward and reverse split.
// ----------------------------------------------------------------------------
module ptdd_scale (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   duty_valid,
  output logic                   duty_ready,
  input  ptdd_pkg::duty_pair_t   duty,
  input  ptdd_pkg::period_pair_t periods,
  ptdd_width_if.source           result
);
  import ptdd_pkg::*;

  localparam int unsigned LANES = 2;

  // Lane 0 is the right wheel, lane 1 the left wheel.
  duty_t             lane_duty   [LANES];
  logic [PERIOD_W-1:0] lane_period [LANES];

  assign lane_duty[0]   = duty.right;
  assign lane_duty[1]   = duty.left;
  assign lane_period[0] = periods.right;
  assign lane_period[1] = periods.left;

  // Stage control.
  logic sa_valid, sb_valid, out_valid;
  logic sa_load, sb_load, sc_load;

  assign sc_load      = !out_valid || result.ready;
  assign sb_load      = !sb_valid || sc_load;
  assign sa_load      = !sa_valid || sb_load;
  assign duty_ready   = sa_load;
  assign result.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      sa_valid  <= 1'b0;
      sb_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (sa_load) sa_valid  <= duty_valid;
      if (sb_load) sb_valid  <= sa_valid;
      if (sc_load) out_valid <= sb_valid;
    end
  end

  logic [PULSE_W-1:0] fwd_width [LANES];
  logic [PULSE_W-1:0] rev_width [LANES];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [29:0]        sa_x, sb_x;
    logic               sa_pos, sb_pos;
    logic [PULSE_W-1:0] sb_quot;
    logic [48:0]        recip_prod;
    logic [29:0]        quot_rem;
    logic [PULSE_W-1:0] quot_fix;

    // Stage A: ticks times duty.
    always_ff @(posedge clk) begin
      if (sa_load) begin
        sa_x   <= 30'(lane_period[l]) * 30'(lane_duty[l].mag);
        sa_pos <= lane_duty[l].pos;
      end
    end

    // Stage B: quotient estimate by full scale.
    assign recip_prod = 49'(sa_x) * 49'(TICK_RECIP);

    always_ff @(posedge clk) begin
      if (sb_load) begin
        sb_x    <= sa_x;
        sb_quot <= recip_prod[47:32];
        sb_pos  <= sa_pos;
      end
    end

    // Stage C: correct the estimate and route it by sign.
    always_comb begin
      quot_rem = sb_x - 30'(sb_quot) * 30'(DUTY_FULL);
      quot_fix = sb_quot + PULSE_W'(quot_rem >= 30'(DUTY_FULL));
    end

    always_ff @(posedge clk) begin
      if (sc_load) begin
        fwd_width[l] <= sb_pos ? quot_fix : '0;
        rev_width[l] <= sb_pos ? '0 : quot_fix;
      end
    end
  end

  assign result.right_forward_width = fwd_width[0];
  assign result.right_reverse_width = rev_width[0];
  assign result.left_forward_width  = fwd_width[1];
  assign result.left_reverse_width  = rev_width[1];
endmodule

/* hw/rtl/polar_to_differential_drive_mixer.sv */
// Throughput: one command word per cycle while the width side is ready; each
// of the seven register stages is at most one multiplier deep, and stalls
// back up stage by stage.
// Reset: synchronous; empties the pipeline and sets both PWM periods to
// 10000 ticks.
// ----------------------------------------------------------------------------
// Polar to differential-drive mixer
// Turns a joystick angle and magnitude into forward and reverse PWM widths
// for the left and right wheels.
// ----------------------------------------------------------------------------
module polar_to_differential_drive_mixer (
  input  logic         clk,
  input  logic         rst,
  ptdd_cmd_if.sink     cmd,
  ptdd_width_if.source result,
  ptdd_cfg_if.sink     cfg
);
  import ptdd_pkg::*;

  logic         duty_valid;
  logic         duty_ready;
  duty_pair_t   duty;
  period_pair_t periods;

  // Period registers.
  ptdd_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .periods (periods)
  );

  // Quadrant decode and duty mixing.
  ptdd_ramp u_ramp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .duty_valid (duty_valid),
    .duty_ready (duty_ready),
    .duty       (duty)
  );

  // Period scaling and sign split.
  ptdd_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .duty_valid (duty_valid),
    .duty_ready (duty_ready),
    .duty       (duty),
    .periods    (periods),
    .result     (result)
  );
endmodule

/* test/polar_to_differential_drive_mixer_tb.sv */
// ----------------------------------------------------------------------------
// Polar mixer testbench
// Feeds joystick command words through the mixer under random valid and ready
// gaps and checks every width word, in order, against a cycle-free predictor.
// ----------------------------------------------------------------------------
module polar_to_differential_drive_mixer_tb;
  import ptdd_pkg::*;

  localparam int RESET_CYCLES    = 6;
  localparam int PIPE_LATENCY    = 7;
  localparam int QUIET_LIMIT     = 2000;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int MAX_REPORTS     = 10;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'd2;

  // Signed copies of the package constants so the duty math stays signed.
  localparam longint QUAD_Q13    = longint'(HALF_PI_Q13);
  localparam longint DUTY_MAX    = longint'(DUTY_FULL);
  localparam longint DUTY_RANGE  = longint'(DUTY_SPAN);
  localparam longint MAG_ONE_Q15 = 32768;

  typedef struct {
    logic signed [ANGLE_W-1:0] angle;
    logic        [MAG_W-1:0]   magnitude;
  } cmd_word_t;

  typedef struct {
    cmd_word_t          cmd;
    logic [PULSE_W-1:0] right_forward_width;
    logic [PULSE_W-1:0] right_reverse_width;
    logic [PULSE_W-1:0] left_forward_width;
    logic [PULSE_W-1:0] left_reverse_width;
  } width_word_t;

  logic clk;
  logic rst;

  ptdd_cmd_if   cmd_ch ();
  ptdd_width_if width_ch ();
  ptdd_cfg_if   cfg_ch ();

  polar_to_differential_drive_mixer uut (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_ch),
    .result (width_ch),
    .cfg    (cfg_ch)
  );

  cmd_word_t           pending_cmds[$];
  width_word_t         expected_widths[$];
  logic [PERIOD_W-1:0] right_period_q;
  logic [PERIOD_W-1:0] left_period_q;
  int                  sender_idle_pct;
  int                  receiver_idle_pct;
  int                  fault_count = 0;
  int                  quiet_cycles = 0;
  bit                  hold_off_req = 1'b0;
  bit                  hold_off_done = 1'b0;
  int                  hold_off_left = 0;

  // Duty of the ramping wheel, truncated toward zero.
  function automatic longint ramp_duty_of(longint mag, longint a);
    longint span;
    span = DUTY_RANGE * a - DUTY_MAX * QUAD_Q13;
    return (mag * span) / (QUAD_Q13 * MAG_ONE_Q15);
  endfunction

  function automatic longint full_duty_of(longint mag);
    return (mag * DUTY_MAX) / MAG_ONE_Q15;
  endfunction

  // Clamp a duty, split it by sign and scale it to timer ticks.
  function automatic void wheel_widths(input longint duty, input logic [PERIOD_W-1:0] period,
                                       output logic [PULSE_W-1:0] fwd,
                                       output logic [PULSE_W-1:0] rev);
    longint clamped;
    longint ticks;
    if (duty > DUTY_MAX) clamped = DUTY_MAX;
    else if (duty < -DUTY_MAX) clamped = -DUTY_MAX;
    else clamped = duty;
    if (clamped > 0) begin
      ticks = (longint'(period) * clamped) / DUTY_MAX;
      fwd = ticks[PULSE_W-1:0];
      rev = '0;
    end else begin
      ticks = (longint'(period) * -clamped) / DUTY_MAX;
      fwd = '0;
      rev = ticks[PULSE_W-1:0];
    end
  endfunction

  function automatic width_word_t predict_widths(cmd_word_t c);
    longint      ang;
    longint      mag;
    longint      mirrored;
    longint      right_duty;
    longint      left_duty;
    width_word_t w;
    ang = c.angle;
    mag = c.magnitude;
    // Upper half-plane ramps one wheel against the other; the lower one mirrors it.
    if (ang > 0) begin
      if (ang > QUAD_Q13) begin
        left_duty  = ramp_duty_of(mag, ang - QUAD_Q13);
        right_duty = full_duty_of(mag);
      end else begin
        right_duty = ramp_duty_of(mag, ang);
        left_duty  = -full_duty_of(mag);
      end
    end else begin
      mirrored = -ang;
      if (mirrored > QUAD_Q13) begin
        right_duty = ramp_duty_of(mag, mirrored - QUAD_Q13);
        left_duty  = full_duty_of(mag);
      end else begin
        left_duty  = ramp_duty_of(mag, mirrored);
        right_duty = -full_duty_of(mag);
      end
    end
    w.cmd = c;
    wheel_widths(right_duty, right_period_q, w.right_forward_width, w.right_reverse_width);
    wheel_widths(left_duty, left_period_q, w.left_forward_width, w.left_reverse_width);
    return w;
  endfunction

  function automatic void queue_cmd(int ang, int mag);
    cmd_word_t c;
    c.angle     = ang[ANGLE_W-1:0];
    c.magnitude = mag[MAG_W-1:0];
    pending_cmds.push_back(c);
  endfunction

  // Mostly commands inside the legal range, some near the quadrant seams,
  // and a few with every bit random.
  task automatic queue_random_cmds(int count);
    int ang;
    int mag;
    int seam;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(9))
        0: begin
          ang = $urandom_range(65535);
          mag = $urandom_range(65535);
        end
        1: begin
          case ($urandom_range(4))
            0: seam = HALF_PI_Q13;
            1: seam = -int'(HALF_PI_Q13);
            2: seam = 0;
            3: seam = HALF_PI_Q13 / 2;
            default: seam = HALF_PI_Q13 + HALF_PI_Q13 / 2;
          endcase
          ang = seam + int'($urandom_range(8)) - 4;
          mag = $urandom_range(32768);
        end
        default: begin
          ang = int'($urandom_range(51472)) - 25736;
          mag = $urandom_range(32768);
        end
      endcase
      queue_cmd(ang, mag);
    end
  endtask

  // Register write; the predictor's copy follows only once the word is taken.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_RIGHT_PERIOD: right_period_q = value;
      REG_LEFT_PERIOD:  left_period_q = value;
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || cmd_ch.valid || expected_widths.size() != 0)
      @(posedge clk);
    repeat (PIPE_LATENCY * 2) @(posedge clk);
  endtask

  // Clock.
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Command driver: offers the next pending word, with random idle gaps, when the bus is free.
  always @(posedge clk) begin
    cmd_word_t taken;
    cmd_word_t next_cmd;
    bit        fire;
    if (rst) begin
      cmd_ch.valid     <= 1'b0;
      cmd_ch.angle     <= '0;
      cmd_ch.magnitude <= '0;
    end else begin
      fire = cmd_ch.valid && cmd_ch.ready;
      if (fire) begin
        taken.angle     = cmd_ch.angle;
        taken.magnitude = cmd_ch.magnitude;
        expected_widths.push_back(predict_widths(taken));
      end
      if (fire || !cmd_ch.valid) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_cmd = pending_cmds.pop_front();
          cmd_ch.angle     <= next_cmd.angle;
          cmd_ch.magnitude <= next_cmd.magnitude;
          cmd_ch.valid     <= 1'b1;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Width monitor: checks each taken word and paces ready.
  always @(posedge clk) begin
    width_word_t want;
    if (rst) begin
      width_ch.ready <= 1'b0;
    end else begin
      if (width_ch.valid && width_ch.ready) begin
        if (expected_widths.size() == 0) begin
          if (fault_count < MAX_REPORTS)
            $display("unexpected width word rf %0d rr %0d lf %0d lr %0d",
                     width_ch.right_forward_width, width_ch.right_reverse_width,
                     width_ch.left_forward_width, width_ch.left_reverse_width);
          fault_count++;
        end else begin
          want = expected_widths.pop_front();
          if (width_ch.right_forward_width !== want.right_forward_width ||
              width_ch.right_reverse_width !== want.right_reverse_width ||
              width_ch.left_forward_width  !== want.left_forward_width  ||
              width_ch.left_reverse_width  !== want.left_reverse_width) begin
            if (fault_count < MAX_REPORTS)
              $display("mismatch angle %0d mag %0d: expected %0d %0d %0d %0d got %0d %0d %0d %0d",
                       want.cmd.angle, want.cmd.magnitude,
                       want.right_forward_width, want.right_reverse_width,
                       want.left_forward_width, want.left_reverse_width,
                       width_ch.right_forward_width, width_ch.right_reverse_width,
                       width_ch.left_forward_width, width_ch.left_reverse_width);
            fault_count++;
          end
        end
      end
      // A long hold-off lets the pipeline fill and back up into the command side.
      if (hold_off_req && !hold_off_done) begin
        hold_off_left = HOLD_OFF_CYCLES;
        hold_off_done = 1'b1;
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        width_ch.ready <= 1'b0;
      end else begin
        width_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  // Watchdog on cycles in which no word moves on any channel.
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (width_ch.valid && width_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    rst              = 1'b1;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;
    right_period_q   = PERIOD_W'(PERIOD_RESET);
    left_period_q    = PERIOD_W'(PERIOD_RESET);
    sender_idle_pct   = 26;
    receiver_idle_pct = 49;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed words at reset periods: quadrant seams, zero-duty ramp points,
    // angles past pi, zero and over-range magnitudes.
    @(negedge clk);
    queue_cmd(0, 32768);
    queue_cmd(1, 32768);
    queue_cmd(-1, 32768);
    queue_cmd(12868, 32768);
    queue_cmd(12869, 32768);
    queue_cmd(-12868, 32768);
    queue_cmd(-12869, 32768);
    queue_cmd(25736, 32768);
    queue_cmd(-25736, 32768);
    queue_cmd(32767, 32768);
    queue_cmd(-32768, 32768);
    queue_cmd(6434, 32768);
    queue_cmd(19302, 32768);
    queue_cmd(-6434, 20000);
    queue_cmd(0, 0);
    queue_cmd(20000, 0);
    queue_cmd(10000, 1);
    queue_cmd(-20000, 32767);
    queue_cmd(5000, 65535);
    queue_cmd(-30000, 65535);
    queue_cmd(25736, 65535);
    queue_cmd(-25736, 40000);
    wait_drained();

    // Extreme periods, sender lightly idle and receiver often stalled.
    write_reg(REG_RIGHT_PERIOD, 16'hFFFF);
    write_reg(REG_LEFT_PERIOD, 16'd1);
    @(negedge clk);
    queue_random_cmds(210);
    wait_drained();

    // Zero right period and a write to an unmapped index, idling swapped.
    sender_idle_pct   = 49;
    receiver_idle_pct = 26;
    write_reg(REG_RIGHT_PERIOD, 16'd0);
    write_reg(REG_LEFT_PERIOD, 16'($urandom_range(65535, 1)));
    write_reg(REG_UNMAPPED + 8'($urandom_range(253)), 16'($urandom_range(65535)));
    @(negedge clk);
    queue_random_cmds(210);
    wait_drained();

    // Random periods at full rate, with one long receiver hold-off.
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    write_reg(REG_RIGHT_PERIOD, 16'($urandom_range(65535, 1)));
    write_reg(REG_LEFT_PERIOD, 16'($urandom_range(65535, 1)));
    @(negedge clk);
    queue_random_cmds(210);
    hold_off_req = 1'b1;
    wait_drained();

    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/ptdd_pkg.sv
hw/rtl/ptdd_cmd_if.sv
hw/rtl/ptdd_width_if.sv
hw/rtl/ptdd_cfg_if.sv
hw/rtl/ptdd_cfg_regs.sv
hw/rtl/ptdd_ramp.sv
hw/rtl/ptdd_scale.sv
hw/rtl/polar_to_differential_drive_mixer.sv
test/polar_to_differential_drive_mixer_tb.sv
